### sv/dlps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared constants and types for the two-tap delay-line pitch shifter.
// ----------------------------------------------------------------------------
package dlps_pkg;

	// Delay line length in frames; a power of two so that pointers wrap freely
	localparam int DELAY_DEPTH = 16384;
	localparam int SAMPLE_BITS = 24;

	localparam int ADDR_W   = $clog2(DELAY_DEPTH);
	localparam int FRAC_W   = 10;
	localparam int POS_W    = ADDR_W + FRAC_W;
	localparam int PHASE_W  = 32;
	localparam int WIN_W    = 14;
	localparam int GAIN_W   = 17;
	localparam int WGT_W    = 27;
	localparam int DLY_SHIFT = 22;
	localparam int OUT_SHIFT = 26;

	// Shared multiplier operand widths (signed)
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 28;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = SAMPLE_BITS + OUT_SHIFT + 4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 14'd2048;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endpackage

### sv/dlps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/delay_line_pitch_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Stereo two-tap delay-line pitch shifter with triangular crossfade.
//
//   channel  signals                                     direction
//   in       in_valid, in_ready, left_in, right_in        into block
//   out      out_valid, out_ready, left_out, right_out    out of block
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data    into block
//
// A shifted frame passes the write, tap-delay, weight, multiply-accumulate and
// saturate steps to the output register; a bypassed frame goes straight there.
// A new frame is taken only while the sequencer is idle. One multiplier is
// shared by all 14 products of a frame (two tap delays, four interpolation
// weights, eight sample products). After reset a clearing pass writes zero to
// every delay-line entry before the first frame is taken.
// A stalled output holds its result; the next frame is taken meanwhile and
// waits in the last step until the output register frees up.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter import dlps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sample_t               left_in,
	input  sample_t               right_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sample_t               left_out,
	output sample_t               right_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_WRITE  = 4'd1;
	localparam logic [3:0] ST_DLY_A  = 4'd2;
	localparam logic [3:0] ST_DLY_B  = 4'd3;
	localparam logic [3:0] ST_WGT_A0 = 4'd4;
	localparam logic [3:0] ST_WGT_A1 = 4'd5;
	localparam logic [3:0] ST_WGT_B0 = 4'd6;
	localparam logic [3:0] ST_WGT_B1 = 4'd7;
	localparam logic [3:0] ST_MAC    = 4'd8;
	localparam logic [3:0] ST_SAT    = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	localparam logic [3:0] MAC_LAST = 4'd8;
	localparam logic [3:0] MAC_LEFT = 4'd4;
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (OUT_SHIFT - 1);
	localparam logic [FRAC_W:0] FRAC_ONE = (FRAC_W+1)'(1) << FRAC_W;

	function automatic sample_t saturate(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] sh;
		logic [ACC_W-SAMPLE_BITS-OUT_SHIFT:0] top;
		sh  = x >>> OUT_SHIFT;
		top = x[ACC_W-1:SAMPLE_BITS+OUT_SHIFT-1];
		if ((&top) || (~|top)) begin
			saturate = sh[SAMPLE_BITS-1:0];
		end else if (x[ACC_W-1]) begin
			saturate = SAT_MIN;
		end else begin
			saturate = SAT_MAX;
		end
	endfunction

	// configuration
	logic                 shift_enabled_q;
	logic [PHASE_W-1:0]   phase_step_q;
	logic [WIN_W-1:0]     window_length_q;

	// control
	logic [3:0]           state_q;
	logic [3:0]           mac_cnt_q;
	logic                 clr_busy_q;
	logic [ADDR_W-1:0]    clr_q;
	logic [ADDR_W-1:0]    wp_q;
	logic [PHASE_W-1:0]   phase_q;
	logic                 out_valid_q;

	// datapath
	sample_t                    res_l_q, res_r_q;
	sample_t                    left_out_q, right_out_q;
	logic [POS_W-1:0]           pos_a_q, pos_b_q;
	logic [WGT_W-1:0]           wgt_q [4];
	sample_t                    smp_l_q [4];
	sample_t                    smp_r_q [4];
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q, sum_l_q, sum_r_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic [PHASE_W-1:0]         phase_b;
	logic [GAIN_W-1:0]          gain_a, gain_b;
	logic [PHASE_W:0]           neg_a, neg_b;
	logic [PROD_W-1:0]          dly_shr;
	logic [POS_W-1:0]           pos_new;
	logic signed [ACC_W-1:0]    acc_sum;
	logic [ADDR_W-1:0]          idx_a, idx_b;
	logic [FRAC_W-1:0]          frac_a, frac_b;
	logic [ADDR_W-1:0]          rd_addr;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [SAMPLE_BITS-1:0]     mem_wdata_l, mem_wdata_r;
	logic [SAMPLE_BITS-1:0]     rd_l, rd_r;
	logic                       in_fire, out_fire;
	logic                       out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !clr_busy_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_fire  = out_valid_q && out_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// triangular gains for both taps
	assign phase_b = {~phase_q[PHASE_W-1], phase_q[PHASE_W-2:0]};
	assign neg_a   = {1'b1, {PHASE_W{1'b0}}} - {1'b0, phase_q};
	assign neg_b   = {1'b1, {PHASE_W{1'b0}}} - {1'b0, phase_b};
	assign gain_a  = phase_q[PHASE_W-1] ? neg_a[PHASE_W-1:15] : {1'b0, phase_q[PHASE_W-2:15]};
	assign gain_b  = phase_b[PHASE_W-1] ? neg_b[PHASE_W-1:15] : {1'b0, phase_b[PHASE_W-2:15]};

	assign idx_a  = pos_a_q[POS_W-1:FRAC_W];
	assign idx_b  = pos_b_q[POS_W-1:FRAC_W];
	assign frac_a = pos_a_q[FRAC_W-1:0];
	assign frac_b = pos_b_q[FRAC_W-1:0];

	// read position behind the advanced write pointer, wrapping over the line
	assign dly_shr = prod_q >> DLY_SHIFT;
	assign pos_new = {wp_q, {FRAC_W{1'b0}}} - dly_shr[POS_W-1:0];
	assign acc_sum = acc_q + ACC_W'(prod_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_WRITE: begin
				mul_a = MUL_A_W'(phase_q);
				mul_b = MUL_B_W'(window_length_q);
			end
			ST_DLY_A: begin
				mul_a = MUL_A_W'(phase_b);
				mul_b = MUL_B_W'(window_length_q);
			end
			ST_DLY_B: begin
				mul_a = MUL_A_W'(FRAC_ONE - {1'b0, frac_a});
				mul_b = MUL_B_W'(gain_a);
			end
			ST_WGT_A0: begin
				mul_a = MUL_A_W'(frac_a);
				mul_b = MUL_B_W'(gain_a);
			end
			ST_WGT_A1: begin
				mul_a = MUL_A_W'(FRAC_ONE - {1'b0, frac_b});
				mul_b = MUL_B_W'(gain_b);
			end
			ST_WGT_B0: begin
				mul_a = MUL_A_W'(frac_b);
				mul_b = MUL_B_W'(gain_b);
			end
			ST_MAC: begin
				if (mac_cnt_q != MAC_LAST) begin
					mul_a = mac_cnt_q[2] ? MUL_A_W'(smp_r_q[mac_cnt_q[1:0]])
					                     : MUL_A_W'(smp_l_q[mac_cnt_q[1:0]]);
					mul_b = MUL_B_W'(wgt_q[mac_cnt_q[1:0]]);
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// read address: both neighbors of tap A, then of tap B
	always_comb begin
		case (state_q)
			ST_DLY_B:  rd_addr = idx_a;
			ST_WGT_A0: rd_addr = idx_a + ADDR_W'(1);
			ST_WGT_A1: rd_addr = idx_b;
			ST_WGT_B0: rd_addr = idx_b + ADDR_W'(1);
			default:   rd_addr = idx_a;
		endcase
	end

	assign mem_we      = clr_busy_q || (state_q == ST_WRITE);
	assign mem_waddr   = clr_busy_q ? clr_q : wp_q;
	assign mem_wdata_l = clr_busy_q ? '0 : res_l_q;
	assign mem_wdata_r = clr_busy_q ? '0 : res_r_q;

	dlps_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DELAY_DEPTH)
	) u_ram_left (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata_l),
		.raddr (rd_addr),
		.rdata (rd_l)
	);

	dlps_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DELAY_DEPTH)
	) u_ram_right (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata_r),
		.raddr (rd_addr),
		.rdata (rd_r)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_enabled_q <= 1'b0;
			phase_step_q    <= '0;
			window_length_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHIFT_ENABLED: shift_enabled_q <= cfg_data[0];
				REG_PHASE_STEP:    phase_step_q    <= cfg_data[PHASE_W-1:0];
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mac_cnt_q   <= '0;
			clr_busy_q  <= 1'b1;
			clr_q       <= '0;
			wp_q        <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(DELAY_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= shift_enabled_q ? ST_WRITE : ST_DONE;
					end
				end
				ST_WRITE: begin
					wp_q    <= wp_q + ADDR_W'(1);
					state_q <= ST_DLY_A;
				end
				ST_DLY_A:  state_q <= ST_DLY_B;
				ST_DLY_B:  state_q <= ST_WGT_A0;
				ST_WGT_A0: state_q <= ST_WGT_A1;
				ST_WGT_A1: state_q <= ST_WGT_B0;
				ST_WGT_B0: state_q <= ST_WGT_B1;
				ST_WGT_B1: begin
					mac_cnt_q <= '0;
					state_q   <= ST_MAC;
				end
				ST_MAC: begin
					mac_cnt_q <= mac_cnt_q + 4'd1;
					if (mac_cnt_q == MAC_LAST) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					phase_q <= phase_q + phase_step_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					res_l_q <= left_in;
					res_r_q <= right_in;
				end
			end
			ST_WRITE: begin
				acc_q <= RND_BIAS;
			end
			ST_DLY_A: begin
				pos_a_q <= pos_new;
			end
			ST_DLY_B: begin
				pos_b_q <= pos_new;
			end
			ST_WGT_A0: begin
				wgt_q[0]   <= prod_q[WGT_W-1:0];
				smp_l_q[0] <= rd_l;
				smp_r_q[0] <= rd_r;
			end
			ST_WGT_A1: begin
				wgt_q[1]   <= prod_q[WGT_W-1:0];
				smp_l_q[1] <= rd_l;
				smp_r_q[1] <= rd_r;
			end
			ST_WGT_B0: begin
				wgt_q[2]   <= prod_q[WGT_W-1:0];
				smp_l_q[2] <= rd_l;
				smp_r_q[2] <= rd_r;
			end
			ST_WGT_B1: begin
				wgt_q[3]   <= prod_q[WGT_W-1:0];
				smp_l_q[3] <= rd_l;
				smp_r_q[3] <= rd_r;
			end
			ST_MAC: begin
				// accumulate the product issued on the previous step
				if (mac_cnt_q == MAC_LEFT) begin
					sum_l_q <= acc_sum;
					acc_q   <= RND_BIAS;
				end else if (mac_cnt_q == MAC_LAST) begin
					sum_r_q <= acc_sum;
				end else if (mac_cnt_q != '0) begin
					acc_q <= acc_sum;
				end
			end
			ST_SAT: begin
				res_l_q <= saturate(sum_l_q);
				res_r_q <= saturate(sum_r_q);
			end
			ST_DONE: begin
				if (out_load) begin
					left_out_q  <= res_l_q;
					right_out_q <= res_r_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("accepted transaction did not start the sequencer");

	a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_WRITE |=> wp_q == $past(wp_q))
		else $error("write pointer moved outside the write step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result presented without finishing a frame");

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> mac_cnt_q <= MAC_LAST)
		else $error("multiply-accumulate counter overran");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |=> state_q == ST_IDLE)
		else $error("frame taken during the clearing pass");

endmodule
